// File: hdl/dcl_pkg.sv
// Shared types and constants for the debugger command lexer.
// Holds the channel payload types, token and error codes, and the
// command format that the front end queues for the back end.
package dcl_pkg;

   // Default capacity of the identifier name buffer, in characters.
   localparam int NAME_CAPACITY_DEFAULT = 32;

   // Depth of the command queue between front and back end.
   localparam int QUEUE_DEPTH = 4;

   // Default radix after reset.
   localparam logic [4:0] RADIX_RESET = 5'd16;

   // Token codes.
   localparam logic [4:0] TOK_EOL    = 5'd0;
   localparam logic [4:0] TOK_ERROR  = 5'd1;
   localparam logic [4:0] TOK_NUMBER = 5'd2;
   localparam logic [4:0] TOK_IDENT  = 5'd3;
   localparam logic [4:0] TOK_DOT    = 5'd4;
   localparam logic [4:0] TOK_DOTDOT = 5'd5;
   localparam logic [4:0] TOK_PLUS   = 5'd6;
   localparam logic [4:0] TOK_MINUS  = 5'd7;
   localparam logic [4:0] TOK_STAR   = 5'd8;
   localparam logic [4:0] TOK_SLASH  = 5'd9;
   localparam logic [4:0] TOK_EQ     = 5'd10;
   localparam logic [4:0] TOK_PCT    = 5'd11;
   localparam logic [4:0] TOK_HASH   = 5'd12;
   localparam logic [4:0] TOK_LPAREN = 5'd13;
   localparam logic [4:0] TOK_RPAREN = 5'd14;
   localparam logic [4:0] TOK_COMMA  = 5'd15;
   localparam logic [4:0] TOK_DITTO  = 5'd16;
   localparam logic [4:0] TOK_DOLLAR = 5'd17;
   localparam logic [4:0] TOK_EXCL   = 5'd18;
   localparam logic [4:0] TOK_SHL    = 5'd19;
   localparam logic [4:0] TOK_SHR    = 5'd20;

   // Error kinds.
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_BAD_CHAR = 3'd1;
   localparam logic [2:0] ERR_BAD_NUM  = 3'd2;
   localparam logic [2:0] ERR_BAD_ESC  = 3'd3;
   localparam logic [2:0] ERR_LONG     = 3'd4;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_line;
   } req_type;

   typedef struct packed {
      logic [4:0]  token_code;
      logic [31:0] number_value;
      logic [7:0]  ident_char;
      logic [4:0]  ident_position;
      logic [2:0]  error_kind;
      logic        last_of_token;
   } rsp_type;

   // Command kinds: write one name character, send one token, or
   // play back the stored name.
   typedef enum logic [1:0] {
      CMD_STORE,
      CMD_TOKEN,
      CMD_NAME
   } cmd_kind_type;

   // For CMD_STORE, value holds the character position; for CMD_NAME,
   // value holds the name length.
   typedef struct packed {
      cmd_kind_type kind;
      logic [4:0]   code;
      logic [31:0]  value;
      logic [2:0]   err;
      logic [7:0]   ch;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// File: hdl/debugger_command_lexer_unit.sv
// Top level of the debugger command lexer.
// Ties front end, command queue, back end and the radix register together.
// Depends on dcl_pkg, dcl_front, dcl_queue and dcl_back.
//
//   channel   direction  handshake            transfer
//   req_      in         req_valid/req_stall  one character or end-of-line mark
//   rsp_      out        rsp_valid/rsp_stall  one token, or one name character
//   csr (APB) in         psel/penable/pready  default_radix at address 0
//
// The front end takes one character per cycle when it yields at most one
// command and the queue has room; a character that ends a token and starts
// another yields two commands and holds the input until both are queued. The
// back end sends a token per cycle when not stalled and plays a name back via
// B_READ and B_SEND per character, set by the registered read of the name
// buffer. The four-entry command queue lets either side stall on its own. Reset
// is synchronous and clears all control state; no clearing pass is needed.
module debugger_command_lexer_unit
   import dcl_pkg::*;
#(
   parameter int NAME_CAPACITY = NAME_CAPACITY_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_payload,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [1:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   logic [4:0]    default_radix_ff;
   logic          push;
   cmd_type       push_data;
   logic          pop;
   cmd_type       head;
   q_status_type  q_status;

   // Only one register, written at address 0; reads at every address return it.
   assign pready = 1'b1;
   assign prdata = {27'd0, default_radix_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         default_radix_ff <= RADIX_RESET;
      end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
         default_radix_ff <= pwdata[4:0];
      end
   end

   // Scan characters and queue commands.
   dcl_front #(
      .NAME_CAPACITY(NAME_CAPACITY)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .default_radix (default_radix_ff),
      .q_status      (q_status),
      .push          (push),
      .push_data     (push_data)
   );

   // Decouple scanning from result delivery.
   dcl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   // Store name characters, send tokens, play names back.
   dcl_back #(
      .NAME_CAPACITY(NAME_CAPACITY)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: hdl/dcl_front.sv
// Front end of the debugger command lexer: scanner state machine.
// Classifies each character and queues commands for the back end.
// Depends on dcl_pkg.
module dcl_front
   import dcl_pkg::*;
#(
   parameter int NAME_CAPACITY = NAME_CAPACITY_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_payload,
   input  logic [4:0]   default_radix,
   input  q_status_type q_status,
   output logic         push,
   output cmd_type      push_data
);

   localparam int LENW = $clog2(NAME_CAPACITY + 1);

   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TILDE  = 8'h7e;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_7      = 8'h37;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3a;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_UNDER  = 8'h5f;
   localparam logic [7:0] CH_DOT    = 8'h2e;
   localparam logic [7:0] CH_LT     = 8'h3c;
   localparam logic [7:0] CH_GT     = 8'h3e;

   typedef enum logic [3:0] {
      F_IDLE, F_ZERO, F_NUM, F_IDENT, F_ESC, F_DOT, F_LT, F_GT, F_FLUSH
   } mode_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_0 && c <= CH_9;
   endfunction

   function automatic cmd_type make_token(input logic [4:0] code, input logic [2:0] err,
                                          input logic [31:0] value);
      cmd_type t;
      t.kind  = CMD_TOKEN;
      t.code  = code;
      t.value = value;
      t.err   = err;
      t.ch    = 8'd0;
      return t;
   endfunction

   mode_type          mode_ff, mode_in;
   logic [4:0]        radix_ff, radix_in;
   logic [31:0]       acc_ff, acc_in;
   logic [LENW-1:0]   len_ff, len_in;
   logic              pend_valid_ff, pend_valid_in;
   cmd_type           pend_ff, pend_in;

   logic [7:0]        c;
   logic              eol;
   logic              accept;

   // idle-step results
   mode_type          idl_mode;
   logic              idl_cmd_valid;
   cmd_type           idl_cmd;
   logic              idl_acc_we;
   logic [31:0]       idl_acc;
   logic              idl_radix_we;
   logic              idl_len_we;
   logic [LENW-1:0]   idl_len;

   // number-step results
   logic [4:0]        num_r;
   logic [31:0]       num_acc;
   logic              num_ok;
   logic              num_bad;
   logic [3:0]        num_digit;
   logic [36:0]       num_prod;
   logic [31:0]       num_next;

   logic [LENW-1:0]   len_p1;
   logic              pre_valid;
   cmd_type           pre_cmd;
   logic              use_idle;
   logic              first_valid, second_valid;
   cmd_type           first_cmd;

   assign c         = req_payload.char_code;
   assign eol       = req_payload.end_of_line;
   assign req_stall = pend_valid_ff || q_status.full;
   assign accept    = req_valid && !req_stall;
   assign len_p1    = len_ff + LENW'(1);

   // Start of a token from the between-tokens state.
   always_comb begin
      idl_mode      = F_IDLE;
      idl_cmd_valid = 1'b0;
      idl_cmd       = make_token(TOK_EOL, ERR_NONE, 32'd0);
      idl_acc_we    = 1'b0;
      idl_acc       = 32'd0;
      idl_radix_we  = 1'b0;
      idl_len_we    = 1'b0;
      idl_len       = '0;
      if (eol || c == CH_NL) begin
         idl_cmd_valid = 1'b1;
      end else if (c <= CH_SPACE || c > CH_TILDE) begin
         idl_mode = F_IDLE;
      end else if (is_digit(c)) begin
         idl_acc_we   = 1'b1;
         idl_radix_we = 1'b1;
         if (c == CH_0) begin
            idl_mode = F_ZERO;
         end else if (default_radix == 5'd8 && c > CH_7) begin
            idl_mode      = F_FLUSH;
            idl_cmd_valid = 1'b1;
            idl_cmd       = make_token(TOK_ERROR, ERR_BAD_NUM, 32'd0);
         end else begin
            idl_mode = F_NUM;
            idl_acc  = 32'(c - CH_0);
         end
      end else if (is_alpha(c) || c == CH_UNDER) begin
         // first name character; no overflow if capacity is at least two, which is not enforced
         idl_mode      = F_IDENT;
         idl_len_we    = 1'b1;
         idl_len       = LENW'(1);
         idl_cmd_valid = 1'b1;
         idl_cmd.kind  = CMD_STORE;
         idl_cmd.code  = TOK_IDENT;
         idl_cmd.value = 32'd0;
         idl_cmd.err   = ERR_NONE;
         idl_cmd.ch    = c;
      end else begin
         idl_cmd_valid = 1'b1;
         case (c)
            CH_BSLASH: begin
               idl_cmd_valid = 1'b0;
               idl_len_we    = 1'b1;
               idl_mode      = F_ESC;
            end
            CH_DOT: begin
               idl_cmd_valid = 1'b0;
               idl_mode      = F_DOT;
            end
            CH_LT: begin
               idl_cmd_valid = 1'b0;
               idl_mode      = F_LT;
            end
            CH_GT: begin
               idl_cmd_valid = 1'b0;
               idl_mode      = F_GT;
            end
            8'h2b: idl_cmd = make_token(TOK_PLUS, ERR_NONE, 32'd0);
            8'h2d: idl_cmd = make_token(TOK_MINUS, ERR_NONE, 32'd0);
            8'h2a: idl_cmd = make_token(TOK_STAR, ERR_NONE, 32'd0);
            8'h2f: idl_cmd = make_token(TOK_SLASH, ERR_NONE, 32'd0);
            8'h3d: idl_cmd = make_token(TOK_EQ, ERR_NONE, 32'd0);
            8'h25: idl_cmd = make_token(TOK_PCT, ERR_NONE, 32'd0);
            8'h23: idl_cmd = make_token(TOK_HASH, ERR_NONE, 32'd0);
            8'h28: idl_cmd = make_token(TOK_LPAREN, ERR_NONE, 32'd0);
            8'h29: idl_cmd = make_token(TOK_RPAREN, ERR_NONE, 32'd0);
            8'h2c: idl_cmd = make_token(TOK_COMMA, ERR_NONE, 32'd0);
            8'h22: idl_cmd = make_token(TOK_DITTO, ERR_NONE, 32'd0);
            8'h24: idl_cmd = make_token(TOK_DOLLAR, ERR_NONE, 32'd0);
            8'h21: idl_cmd = make_token(TOK_EXCL, ERR_NONE, 32'd0);
            default: begin
               idl_mode = F_FLUSH;
               idl_cmd  = make_token(TOK_ERROR, ERR_BAD_CHAR, 32'd0);
            end
         endcase
      end
   end

   // One digit of a number; right after a leading zero the default radix
   // applies and the accumulator starts from zero.
   always_comb begin
      num_r     = (mode_ff == F_ZERO) ? default_radix : radix_ff;
      num_acc   = (mode_ff == F_ZERO) ? 32'd0 : acc_ff;
      num_ok    = 1'b0;
      num_digit = 4'd0;
      if (!eol) begin
         if (c >= CH_0 && c <= ((num_r == 5'd8) ? CH_7 : CH_9)) begin
            num_ok    = 1'b1;
            num_digit = 4'(c - CH_0);
         end else if (num_r == 5'd16 && c >= 8'h61 && c <= 8'h66) begin
            num_ok    = 1'b1;
            num_digit = 4'(c - 8'h57);
         end else if (num_r == 5'd16 && c >= 8'h41 && c <= 8'h46) begin
            num_ok    = 1'b1;
            num_digit = 4'(c - 8'h37);
         end
      end
      num_bad  = !num_ok && !eol && (is_digit(c) || is_alpha(c) || c == CH_UNDER);
      num_prod = num_acc * num_r;
      num_next = num_prod[31:0] + 32'(num_digit);
   end

   always_comb begin
      mode_in   = mode_ff;
      radix_in  = radix_ff;
      acc_in    = acc_ff;
      len_in    = len_ff;
      pre_valid = 1'b0;
      pre_cmd   = make_token(TOK_EOL, ERR_NONE, 32'd0);
      use_idle  = 1'b0;
      case (mode_ff)
         F_FLUSH: begin
            if (eol) begin
               mode_in = F_IDLE;
            end
         end
         F_ZERO, F_NUM: begin
            if (mode_ff == F_ZERO) begin
               acc_in   = 32'd0;
               mode_in  = F_NUM;
               radix_in = default_radix;
            end
            if (mode_ff == F_ZERO && !eol && (c == 8'h6f || c == 8'h4f)) begin
               radix_in = 5'd8;
            end else if (mode_ff == F_ZERO && !eol && (c == 8'h74 || c == 8'h54)) begin
               radix_in = 5'd10;
            end else if (mode_ff == F_ZERO && !eol && (c == 8'h78 || c == 8'h58)) begin
               radix_in = 5'd16;
            end else if (num_ok) begin
               acc_in = num_next;
            end else if (num_bad) begin
               mode_in   = F_FLUSH;
               pre_valid = 1'b1;
               pre_cmd   = make_token(TOK_ERROR, ERR_BAD_NUM, 32'd0);
            end else begin
               // number ends; this character starts the next token
               pre_valid = 1'b1;
               pre_cmd   = make_token(TOK_NUMBER, ERR_NONE, num_acc);
               use_idle  = 1'b1;
            end
         end
         F_ESC, F_IDENT: begin
            if (mode_ff == F_ESC && (eol || c == CH_NL)) begin
               mode_in   = eol ? F_IDLE : F_FLUSH;
               pre_valid = 1'b1;
               pre_cmd   = make_token(TOK_ERROR, ERR_BAD_ESC, 32'd0);
            end else if (mode_ff == F_IDENT && !eol && c == CH_BSLASH) begin
               mode_in = F_ESC;
            end else if (mode_ff == F_ESC ||
                         (!eol && (is_alpha(c) || is_digit(c) ||
                                   c == CH_UNDER || c == CH_COLON))) begin
               len_in    = len_p1;
               pre_valid = 1'b1;
               if (len_p1 >= LENW'(NAME_CAPACITY)) begin
                  mode_in = F_FLUSH;
                  pre_cmd = make_token(TOK_ERROR, ERR_LONG, 32'd0);
               end else begin
                  mode_in       = F_IDENT;
                  pre_cmd.kind  = CMD_STORE;
                  pre_cmd.code  = TOK_IDENT;
                  pre_cmd.value = 32'(len_ff);
                  pre_cmd.ch    = c;
               end
            end else begin
               // name ends: play it back, then start the next token
               pre_valid     = 1'b1;
               pre_cmd.kind  = CMD_NAME;
               pre_cmd.code  = TOK_IDENT;
               pre_cmd.value = 32'(len_ff);
               use_idle      = 1'b1;
            end
         end
         F_DOT: begin
            mode_in   = F_IDLE;
            pre_valid = 1'b1;
            if (!eol && c == CH_DOT) begin
               pre_cmd = make_token(TOK_DOTDOT, ERR_NONE, 32'd0);
            end else begin
               pre_cmd  = make_token(TOK_DOT, ERR_NONE, 32'd0);
               use_idle = 1'b1;
            end
         end
         F_LT, F_GT: begin
            mode_in   = F_IDLE;
            pre_valid = 1'b1;
            if (!eol && c == ((mode_ff == F_LT) ? CH_LT : CH_GT)) begin
               pre_cmd = make_token((mode_ff == F_LT) ? TOK_SHL : TOK_SHR,
                                    ERR_NONE, 32'd0);
            end else begin
               mode_in = eol ? F_IDLE : F_FLUSH;
               pre_cmd = make_token(TOK_ERROR, ERR_BAD_CHAR, 32'd0);
            end
         end
         default: begin
            use_idle = 1'b1;
         end
      endcase
      if (use_idle) begin
         mode_in = idl_mode;
         if (idl_acc_we) begin
            acc_in = idl_acc;
         end
         if (idl_radix_we) begin
            radix_in = default_radix;
         end
         if (idl_len_we) begin
            len_in = idl_len;
         end
      end
   end

   always_comb begin
      first_valid  = pre_valid || (use_idle && idl_cmd_valid);
      first_cmd    = pre_valid ? pre_cmd : idl_cmd;
      second_valid = pre_valid && use_idle && idl_cmd_valid;
      push         = pend_valid_ff ? !q_status.full : (accept && first_valid);
      push_data    = pend_valid_ff ? pend_ff : first_cmd;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (accept) begin
         pend_valid_in = second_valid;
         pend_in       = idl_cmd;
      end else if (pend_valid_ff && !q_status.full) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= F_IDLE;
         radix_ff      <= 5'd0;
         acc_ff        <= 32'd0;
         len_ff        <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         pend_ff       <= pend_in;
         if (accept) begin
            mode_ff  <= mode_in;
            radix_ff <= radix_in;
            acc_ff   <= acc_in;
            len_ff   <= len_in;
         end
      end
   end

endmodule

// File: hdl/dcl_queue.sv
// Command queue between the lexer front end and back end.
// Small flop FIFO with the head entry visible. Depends on dcl_pkg.
module dcl_queue
   import dcl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_data,
   input  logic         pop,
   output cmd_type      head,
   output q_status_type status
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   cmd_type        slots_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]    count_ff;

   assign head         = slots_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (PW + 1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (PW + 1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (PW + 1)'(1);
         end
      end
   end

endmodule

// File: hdl/dcl_back.sv
// Back end of the debugger command lexer: executes queued commands.
// Owns the name buffer and the result register. Depends on dcl_pkg.
module dcl_back
   import dcl_pkg::*;
#(
   parameter int NAME_CAPACITY = NAME_CAPACITY_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      head,
   input  q_status_type q_status,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_payload
);

   localparam int IDXW = $clog2(NAME_CAPACITY);

   typedef enum logic [1:0] {
      B_IDLE, B_READ, B_SEND
   } bstate_type;

   bstate_type       st_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   logic [IDXW-1:0]  idx_ff;
   logic [IDXW-1:0]  len_ff;
   logic [7:0]       name_mem [NAME_CAPACITY];
   logic [7:0]       rd_data_ff;

   logic             out_free;
   logic             mem_we;
   logic             last_char;
   logic [31:0]      idx_wide;
   logic             load_tok;
   logic             load_chr;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign pop         = (st_ff == B_IDLE) && !q_status.empty &&
                        (head.kind != CMD_TOKEN || out_free);
   assign mem_we      = pop && head.kind == CMD_STORE;
   assign last_char   = ({1'b0, idx_ff} + (IDXW + 1)'(1)) == {1'b0, len_ff};
   assign idx_wide    = 32'(idx_ff);
   assign load_tok    = pop && head.kind == CMD_TOKEN;
   assign load_chr    = (st_ff == B_SEND) && out_free;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         name_mem[head.value[IDXW-1:0]] <= head.ch;
      end
      rd_data_ff <= name_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_tok || load_chr) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (st_ff)
            B_IDLE: begin
               if (pop) begin
                  case (head.kind)
                     CMD_TOKEN: begin
                        rsp_ff.token_code     <= head.code;
                        rsp_ff.number_value   <= head.value;
                        rsp_ff.ident_char     <= 8'd0;
                        rsp_ff.ident_position <= 5'd0;
                        rsp_ff.error_kind     <= head.err;
                        rsp_ff.last_of_token  <= 1'b1;
                     end
                     CMD_NAME: begin
                        idx_ff <= '0;
                        len_ff <= head.value[IDXW-1:0];
                        st_ff  <= B_READ;
                     end
                     default: begin
                        st_ff <= B_IDLE;
                     end
                  endcase
               end
            end
            B_READ: begin
               st_ff <= B_SEND;
            end
            B_SEND: begin
               if (out_free) begin
                  rsp_ff.token_code     <= TOK_IDENT;
                  rsp_ff.number_value   <= 32'd0;
                  rsp_ff.ident_char     <= rd_data_ff;
                  rsp_ff.ident_position <= idx_wide[4:0];
                  rsp_ff.error_kind     <= ERR_NONE;
                  rsp_ff.last_of_token  <= last_char;
                  if (last_char) begin
                     st_ff <= B_IDLE;
                  end else begin
                     idx_ff <= idx_ff + IDXW'(1);
                     st_ff  <= B_READ;
                  end
               end
            end
            default: begin
               st_ff <= B_IDLE;
            end
         endcase
      end
   end

endmodule
